// ===== hw/rtl/wkc_pkg.sv =====
`default_nettype none

package wkc_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_KERNEL   = 5;
   localparam int PIXEL_BITS   = 16;
   localparam int SMALL_KERNEL = 3;
   localparam int COEF_BITS    = 8;
   localparam int TAPS         = MAX_KERNEL * MAX_KERNEL;
   localparam int LINES        = MAX_KERNEL - 1;
   localparam int LINE_BITS    = LINES * PIXEL_BITS;
   localparam int COL_BITS     = $clog2(MAX_WIDTH);
   localparam int DIM_BITS     = 11;
   localparam int MIN_DIM      = 8;
   localparam int SHIFT_BITS   = 4;
   localparam int PROD_BITS    = PIXEL_BITS + COEF_BITS;
   localparam int ROW_SUM_BITS = PROD_BITS + $clog2(MAX_KERNEL);
   localparam int SUM_BITS     = PROD_BITS + $clog2(TAPS);

   localparam int OUT_DEPTH      = 16;
   localparam int OUT_PTR_BITS   = $clog2(OUT_DEPTH);
   localparam int OUT_COUNT_BITS = OUT_PTR_BITS + 1;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_KERNEL_SELECT = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_WORD0    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_WORD1    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_WORD2    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_WORD3    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE_SHIFT   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH   = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT  = 3'd7;

   typedef logic signed [PIXEL_BITS-1:0] pixel_type;
   typedef pixel_type [MAX_KERNEL-1:0][MAX_KERNEL-1:0] window_type;

   typedef struct packed {
      logic      kind;
      pixel_type pixel_in;
   } req_payload_type;

   typedef struct packed {
      pixel_type pixel_out;
      logic      frame_last;
   } rsp_payload_type;

   typedef struct packed {
      logic                     kernel_select;
      logic [TAPS*COEF_BITS-1:0] coefs;
      logic [SHIFT_BITS-1:0]    scale_shift;
      logic [DIM_BITS-1:0]      frame_width;
      logic [DIM_BITS-1:0]      frame_height;
   } csr_type;

   // one accepted item on its way into the window
   typedef struct packed {
      logic                shift;
      logic                emit;
      logic                border;
      logic                last;
      logic [COL_BITS-1:0] col;
      pixel_type           pixel;
   } item_ctl_type;

   typedef struct packed {
      logic valid;
      logic border;
      logic last;
   } tag_type;

endpackage

`default_nettype wire

// ===== hw/rtl/wkc_ctrl.sv =====
`default_nettype none

module wkc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  wkc_pkg::req_payload_type req_data,
   input  wkc_pkg::csr_type         csr,
   output logic                     item_emit,
   output wkc_pkg::item_ctl_type    ctl
);
   import wkc_pkg::*;

   logic [COL_BITS-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [DIM_BITS-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   item_ctl_type        ctl_ff, ctl_in;

   logic [DIM_BITS-1:0] width, height, radius, in_col_ext, out_col_ext;
   logic [DIM_BITS:0]   out_row_ext, radius_ext, height_ext;
   logic                frame_done, is_pixel, past_latency, item_shift;
   logic                in_col_wrap, out_col_wrap, out_last, border;

   always_comb begin
      if (csr.frame_width < DIM_BITS'(MIN_DIM)) begin
         width = DIM_BITS'(MIN_DIM);
      end else if (csr.frame_width > DIM_BITS'(MAX_WIDTH)) begin
         width = DIM_BITS'(MAX_WIDTH);
      end else begin
         width = csr.frame_width;
      end
      if (csr.frame_height < DIM_BITS'(MIN_DIM)) begin
         height = DIM_BITS'(MIN_DIM);
      end else begin
         height = csr.frame_height;
      end
   end

   assign radius      = csr.kernel_select ? DIM_BITS'(MAX_KERNEL / 2)
                                          : DIM_BITS'(SMALL_KERNEL / 2);
   assign in_col_ext  = DIM_BITS'(in_col_ff);
   assign out_col_ext = DIM_BITS'(out_col_ff);
   assign out_row_ext = (DIM_BITS + 1)'(out_row_ff);
   assign radius_ext  = (DIM_BITS + 1)'(radius);
   assign height_ext  = (DIM_BITS + 1)'(height);

   assign frame_done   = in_row_ff >= height;
   assign is_pixel     = !frame_done && !req_data.kind;
   assign past_latency = (in_row_ff > radius) ||
                         ((in_row_ff == radius) && (in_col_ext >= radius));
   assign item_shift   = frame_done || is_pixel;
   assign item_emit    = frame_done || (is_pixel && past_latency);

   assign in_col_wrap  = in_col_ext + DIM_BITS'(1) >= width;
   assign out_col_wrap = out_col_ext + DIM_BITS'(1) >= width;
   assign out_last     = (out_row_ext + (DIM_BITS + 1)'(1) >= height_ext) && out_col_wrap;
   assign border       = (out_row_ff < radius) ||
                         (out_row_ext + radius_ext >= height_ext) ||
                         (out_col_ext < radius) ||
                         (out_col_ext + radius >= width);

   // after the frame the write column keeps running so the window stays in step
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (accept && item_shift) begin
         in_col_in = in_col_wrap ? '0 : in_col_ff + COL_BITS'(1);
      end
      if (accept && is_pixel && in_col_wrap) begin
         in_row_in = in_row_ff + DIM_BITS'(1);
      end
      if (accept && item_emit) begin
         if (out_last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else if (out_col_wrap) begin
            out_col_in = '0;
            out_row_in = out_row_ff + DIM_BITS'(1);
         end else begin
            out_col_in = out_col_ff + COL_BITS'(1);
         end
      end
   end

   always_comb begin
      ctl_in.shift  = accept && item_shift;
      ctl_in.emit   = item_emit;
      ctl_in.border = border;
      ctl_in.last   = out_last;
      ctl_in.col    = in_col_ff;
      ctl_in.pixel  = req_data.pixel_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         ctl_ff.shift <= 1'b0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         ctl_ff     <= ctl_in;
      end
   end

   assign ctl = ctl_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/wkc_window.sv =====
`default_nettype none

module wkc_window (
   input  logic                  clock,
   input  logic                  reset,
   input  wkc_pkg::item_ctl_type ctl,
   output wkc_pkg::window_type   window_taps,
   output wkc_pkg::tag_type      tag
);
   import wkc_pkg::*;

   logic [LINE_BITS-1:0] line_mem [MAX_WIDTH];
   logic [LINE_BITS-1:0] rd_data_ff;
   item_ctl_type         s2_ff;
   window_type           win_ff;
   tag_type              tag_ff;
   pixel_type            col_vec [MAX_KERNEL];

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         rd_data_ff <= line_mem[ctl.col];
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ff.shift) begin
         line_mem[s2_ff.col] <= {rd_data_ff[LINE_BITS-PIXEL_BITS-1:0], s2_ff.pixel};
      end
   end

   // row delay 0 is the new pixel, row delay d comes from line d-1
   always_comb begin
      col_vec[0] = s2_ff.pixel;
      for (int d = 1; d < MAX_KERNEL; d++) begin
         col_vec[d] = rd_data_ff[(d-1)*PIXEL_BITS +: PIXEL_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ff.shift) begin
         for (int d = 0; d < MAX_KERNEL; d++) begin
            for (int j = MAX_KERNEL - 1; j > 0; j--) begin
               win_ff[d][j] <= win_ff[d][j-1];
            end
            win_ff[d][0] <= col_vec[d];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.shift  <= 1'b0;
         tag_ff.valid <= 1'b0;
      end else begin
         s2_ff        <= ctl;
         tag_ff.valid <= s2_ff.shift && s2_ff.emit;
      end
      tag_ff.border <= s2_ff.border;
      tag_ff.last   <= s2_ff.last;
   end

   assign window_taps = win_ff;
   assign tag         = tag_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/wkc_mac.sv =====
`default_nettype none

module wkc_mac (
   input  logic                     clock,
   input  logic                     reset,
   input  wkc_pkg::csr_type         csr,
   input  wkc_pkg::window_type      window_taps,
   input  wkc_pkg::tag_type         tag,
   output logic                     res_valid,
   output wkc_pkg::rsp_payload_type res_data
);
   import wkc_pkg::*;

   typedef struct packed {
      logic      valid;
      logic      border;
      logic      last;
      pixel_type center;
   } mac_tag_type;

   localparam logic signed [SUM_BITS-1:0] SAT_HI = SUM_BITS'((1 << (PIXEL_BITS - 1)) - 1);
   localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - SUM_BITS'(1);

   logic signed [PROD_BITS-1:0]    prod_ff [MAX_KERNEL][MAX_KERNEL];
   logic signed [ROW_SUM_BITS-1:0] row_sum_ff [MAX_KERNEL];
   logic signed [ROW_SUM_BITS-1:0] row_sum_in [MAX_KERNEL];
   logic signed [SUM_BITS-1:0]     sum_ff, sum_in, shifted;
   pixel_type                      sat_value;
   mac_tag_type                    p_tag_ff, p_tag_in, r_tag_ff, s_tag_ff;

   // tap (d, j) holds the pixel d rows and j columns behind the newest one
   for (genvar d = 0; d < MAX_KERNEL; d++) begin : g_row
      for (genvar j = 0; j < MAX_KERNEL; j++) begin : g_tap
         localparam int IDX_FULL = (MAX_KERNEL - 1 - d) * MAX_KERNEL + (MAX_KERNEL - 1 - j);
         localparam bit IN_SMALL = (d < SMALL_KERNEL) && (j < SMALL_KERNEL);
         localparam int IDX_SMALL = IN_SMALL ?
            (SMALL_KERNEL - 1 - d) * SMALL_KERNEL + (SMALL_KERNEL - 1 - j) : 0;
         logic signed [COEF_BITS-1:0] coef;

         always_comb begin
            if (csr.kernel_select) begin
               coef = $signed(csr.coefs[IDX_FULL*COEF_BITS +: COEF_BITS]);
            end else if (IN_SMALL) begin
               coef = $signed(csr.coefs[IDX_SMALL*COEF_BITS +: COEF_BITS]);
            end else begin
               coef = '0;
            end
         end

         // taps outside the small kernel may hold unwritten line data
         always_ff @(posedge clock) begin
            if (csr.kernel_select || IN_SMALL) begin
               prod_ff[d][j] <= $signed(window_taps[d][j]) * coef;
            end else begin
               prod_ff[d][j] <= '0;
            end
         end
      end
   end

   always_comb begin
      p_tag_in.valid  = tag.valid;
      p_tag_in.border = tag.border;
      p_tag_in.last   = tag.last;
      p_tag_in.center = csr.kernel_select ? window_taps[MAX_KERNEL/2][MAX_KERNEL/2]
                                          : window_taps[SMALL_KERNEL/2][SMALL_KERNEL/2];
   end

   always_comb begin
      for (int d = 0; d < MAX_KERNEL; d++) begin
         row_sum_in[d] = '0;
         for (int j = 0; j < MAX_KERNEL; j++) begin
            row_sum_in[d] = row_sum_in[d] + ROW_SUM_BITS'(prod_ff[d][j]);
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int d = 0; d < MAX_KERNEL; d++) begin
         sum_in = sum_in + SUM_BITS'(row_sum_ff[d]);
      end
   end

   always_ff @(posedge clock) begin
      row_sum_ff <= row_sum_in;
      sum_ff     <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_tag_ff.valid <= 1'b0;
         r_tag_ff.valid <= 1'b0;
         s_tag_ff.valid <= 1'b0;
      end else begin
         p_tag_ff <= p_tag_in;
         r_tag_ff <= p_tag_ff;
         s_tag_ff <= r_tag_ff;
      end
   end

   // floor shift, then clamp to the pixel range
   always_comb begin
      shifted = sum_ff >>> csr.scale_shift;
      if (shifted > SAT_HI) begin
         sat_value = SAT_HI[PIXEL_BITS-1:0];
      end else if (shifted < SAT_LO) begin
         sat_value = SAT_LO[PIXEL_BITS-1:0];
      end else begin
         sat_value = shifted[PIXEL_BITS-1:0];
      end
   end

   assign res_valid           = s_tag_ff.valid;
   assign res_data.pixel_out  = s_tag_ff.border ? s_tag_ff.center : sat_value;
   assign res_data.frame_last = s_tag_ff.last;

endmodule

`default_nettype wire

// ===== hw/rtl/wkc_out_fifo.sv =====
`default_nettype none

module wkc_out_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  wkc_pkg::rsp_payload_type push_data,
   input  logic                     pop,
   output logic                     out_valid,
   output wkc_pkg::rsp_payload_type out_data
);
   import wkc_pkg::*;

   rsp_payload_type           entries [OUT_DEPTH];
   logic [OUT_PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [OUT_COUNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + OUT_COUNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - OUT_COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + OUT_PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + OUT_PTR_BITS'(1);
         end
         count_ff <= count_in;
      end
   end

   assign out_valid = count_ff != '0;
   assign out_data  = entries[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== hw/rtl/window_kernel_convolution.sv =====
`default_nettype none

// Streaming 3x3 / 5x5 correlation over a raster-order frame of signed 16-bit
// pixels. One item per clock while req_stall is low: pixels write a 1024 x
// 64-bit line memory (four previous rows) and shift a 5x5 window; 25 parallel
// 16x8 multipliers, a row and a column adder stage, then floor shift and
// 16-bit saturation. A result passes the control register, then the memory
// read, window, multiplier and two adder registers, and queues in a 16-entry
// output FIFO; req_stall rises only while 16 results are accepted but not yet
// taken. Pixels within the kernel radius of an edge come out unchanged, and
// the last r rows plus r pixels come out on any items sent after the frame,
// the final one flagged frame_last. Write registers only between frames.
module window_kernel_convolution (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  wkc_pkg::req_payload_type              req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output wkc_pkg::rsp_payload_type              rsp_data,
   input  logic                                  csr_write,
   input  logic [wkc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [wkc_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import wkc_pkg::*;

   csr_type                   csr_ff;
   logic [OUT_COUNT_BITS-1:0] outstanding_ff, outstanding_in;
   logic                      accept, pop, item_emit, res_valid;
   item_ctl_type              ctl;
   window_type                window_taps;
   tag_type                   tag;
   rsp_payload_type           res_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.kernel_select <= 1'b0;
         csr_ff.coefs         <= '0;
         csr_ff.scale_shift   <= '0;
         csr_ff.frame_width   <= DIM_BITS'(MIN_DIM);
         csr_ff.frame_height  <= DIM_BITS'(MIN_DIM);
      end else if (csr_write) begin
         case (csr_index)
            CSR_KERNEL_SELECT: begin
               csr_ff.kernel_select <= csr_data[0];
            end
            CSR_COEF_WORD0: begin
               csr_ff.coefs[0 +: CSR_DATA_BITS] <= csr_data;
            end
            CSR_COEF_WORD1: begin
               csr_ff.coefs[CSR_DATA_BITS +: CSR_DATA_BITS] <= csr_data;
            end
            CSR_COEF_WORD2: begin
               csr_ff.coefs[2*CSR_DATA_BITS +: CSR_DATA_BITS] <= csr_data;
            end
            CSR_COEF_WORD3: begin
               csr_ff.coefs[3*CSR_DATA_BITS +: COEF_BITS] <= csr_data[COEF_BITS-1:0];
            end
            CSR_SCALE_SHIFT: begin
               csr_ff.scale_shift <= csr_data[SHIFT_BITS-1:0];
            end
            CSR_FRAME_WIDTH: begin
               csr_ff.frame_width <= csr_data[DIM_BITS-1:0];
            end
            CSR_FRAME_HEIGHT: begin
               csr_ff.frame_height <= csr_data[DIM_BITS-1:0];
            end
            default: begin
               csr_ff <= csr_ff;
            end
         endcase
      end
   end

   assign req_stall = outstanding_ff == OUT_COUNT_BITS'(OUT_DEPTH);
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (accept && item_emit && !pop) begin
         outstanding_in = outstanding_ff + OUT_COUNT_BITS'(1);
      end else if (pop && !(accept && item_emit)) begin
         outstanding_in = outstanding_ff - OUT_COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   wkc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .csr       (csr_ff),
      .item_emit (item_emit),
      .ctl       (ctl)
   );

   wkc_window u_window (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .window_taps (window_taps),
      .tag         (tag)
   );

   wkc_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr_ff),
      .window_taps (window_taps),
      .tag         (tag),
      .res_valid   (res_valid),
      .res_data    (res_data)
   );

   wkc_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== bench/window_kernel_convolution_check.sv =====
`timescale 1ns / 100ps

module window_kernel_convolution_check
   import wkc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  req_payload_type           req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  rsp_payload_type           rsp_data,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output int                        failures,
   output int                        pending
);

   localparam logic   KIND_FLUSH    = 1'b1;
   localparam int     HISTORY_DEPTH = MAX_KERNEL * MAX_WIDTH;
   localparam longint PIXEL_MAX     = (longint'(1) << (PIXEL_BITS - 1)) - 1;
   localparam longint PIXEL_MIN     = -PIXEL_MAX - 1;

   pixel_type                history [HISTORY_DEPTH];
   logic                     kernel_5x5;
   logic [CSR_DATA_BITS-1:0] coef_words [4];
   logic [SHIFT_BITS-1:0]    shift_amount;
   logic [DIM_BITS-1:0]      width_reg;
   logic [DIM_BITS-1:0]      height_reg;
   int unsigned              in_col, in_row, out_col, out_row;
   rsp_payload_type          expected_pixels [$];

   function automatic longint coef(int unsigned k);
      logic [CSR_DATA_BITS-1:0]    word;
      logic signed [COEF_BITS-1:0] tap;
      word = coef_words[k / 8];
      tap = word[(k % 8) * COEF_BITS +: COEF_BITS];
      return longint'(tap);
   endfunction

   function automatic int unsigned active_width();
      if (width_reg < MIN_DIM) return MIN_DIM;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
   endfunction

   function automatic int unsigned active_height();
      return (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
   endfunction

   // correlation sum or border pass-through for the pixel at the output position
   function automatic rsp_payload_type next_output(int unsigned w, int unsigned h,
                                                   int unsigned r);
      int unsigned     span;
      int unsigned     pos;
      longint          acc;
      rsp_payload_type res;
      span = 2 * r + 1;
      if (out_row < r || out_row + r >= h || out_col < r || out_col + r >= w) begin
         res.pixel_out = history[(out_row * w + out_col) % HISTORY_DEPTH];
      end else begin
         acc = 0;
         for (int unsigned dy = 0; dy < span; dy++) begin
            for (int unsigned dx = 0; dx < span; dx++) begin
               pos = ((out_row + dy - r) * w + out_col + dx - r) % HISTORY_DEPTH;
               acc += longint'(history[pos]) * coef(dy * span + dx);
            end
         end
         acc = acc >>> shift_amount;
         if (acc > PIXEL_MAX) acc = PIXEL_MAX;
         if (acc < PIXEL_MIN) acc = PIXEL_MIN;
         res.pixel_out = pixel_type'(acc);
      end
      res.frame_last = (out_row + 1 >= h) && (out_col + 1 >= w);
      if (res.frame_last) begin
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
      end else if (out_col + 1 >= w) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
      return res;
   endfunction

   function automatic bit predict_item(input req_payload_type item,
                                       output rsp_payload_type res);
      int unsigned w, h, r, pos;
      w = active_width();
      h = active_height();
      r = kernel_5x5 ? MAX_KERNEL / 2 : SMALL_KERNEL / 2;
      res = '0;
      // frame fully in: every item drains one output
      if (in_row >= h) begin
         res = next_output(w, h, r);
         return 1'b1;
      end
      if (item.kind == KIND_FLUSH) return 1'b0;
      pos = in_row * w + in_col;
      history[pos % HISTORY_DEPTH] = item.pixel_in;
      if (in_col + 1 >= w) begin
         in_col = 0;
         in_row++;
      end else begin
         in_col++;
      end
      if (out_row * w + out_col + r * w + r <= pos) begin
         res = next_output(w, h, r);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_payload_type produced;
      rsp_payload_type want;
      if (reset) begin
         kernel_5x5 = 1'b0;
         foreach (coef_words[i]) coef_words[i] = '0;
         shift_amount = '0;
         width_reg = DIM_BITS'(MIN_DIM);
         height_reg = DIM_BITS'(MIN_DIM);
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
         expected_pixels.delete();
         failures = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_KERNEL_SELECT: kernel_5x5 = csr_data[0];
               CSR_COEF_WORD0:    coef_words[0] = csr_data;
               CSR_COEF_WORD1:    coef_words[1] = csr_data;
               CSR_COEF_WORD2:    coef_words[2] = csr_data;
               CSR_COEF_WORD3:    coef_words[3] = csr_data;
               CSR_SCALE_SHIFT:   shift_amount = csr_data[SHIFT_BITS-1:0];
               CSR_FRAME_WIDTH:   width_reg = csr_data[DIM_BITS-1:0];
               CSR_FRAME_HEIGHT:  height_reg = csr_data[DIM_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (predict_item(req_data, produced)) expected_pixels.push_back(produced);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected item: pixel_out %0d frame_last %0b",
                      rsp_data.pixel_out, rsp_data.frame_last);
               failures++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_data.pixel_out !== want.pixel_out) begin
                  $error("pixel_out: expected %0d, got %0d",
                         want.pixel_out, rsp_data.pixel_out);
                  failures++;
               end
               if (rsp_data.frame_last !== want.frame_last) begin
                  $error("frame_last: expected %0b, got %0b",
                         want.frame_last, rsp_data.frame_last);
                  failures++;
               end
            end
         end
      end
      pending = expected_pixels.size();
   end

endmodule

// ===== bench/window_kernel_convolution_test.sv =====
`timescale 1ns / 100ps

module window_kernel_convolution_test;
   import wkc_pkg::*;

   localparam logic      KIND_PIXEL     = 1'b0;
   localparam logic      KIND_FLUSH     = 1'b1;
   localparam pixel_type PIXEL_HIGH     = pixel_type'(16'h7fff);
   localparam pixel_type PIXEL_LOW      = pixel_type'(16'h8000);
   localparam int        RESET_CYCLES   = 10;
   localparam int        SETTLE_CYCLES  = 20;
   localparam int        HOLD_CYCLES    = 400;
   localparam int        WATCHDOG_LIMIT = 5000;
   localparam int        ITEM_TARGET    = 1950;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_payload_type           req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_payload_type           rsp_data;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   int          failures;
   int          pending;
   int          sent_items = 0;
   int          quiet_cycles = 0;
   bit          sender_dense = 1'b0;
   bit          long_hold_req = 1'b0;
   int unsigned geo_width, geo_height, geo_radius;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   window_kernel_convolution dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   window_kernel_convolution_check pixel_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .failures  (failures),
      .pending   (pending)
   );

   function automatic int sender_gap();
      int roll;
      if (sender_dense) return 0;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic pixel_type random_pixel();
      if ($urandom_range(99) < 12) begin
         case ($urandom_range(3))
            0: return PIXEL_HIGH;
            1: return PIXEL_LOW;
            2: return '0;
            default: return '1;
         endcase
      end
      return pixel_type'($urandom);
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] random_coefs();
      logic [CSR_DATA_BITS-1:0] word;
      if ($urandom_range(1)) return {$urandom, $urandom};
      // small taps, -4..4, for smaller sums than fully random taps give
      for (int b = 0; b < 8; b++) word[b * COEF_BITS +: COEF_BITS] = COEF_BITS'($urandom_range(8) + 252);
      return word;
   endfunction

   task automatic send_item(input logic item_kind, input pixel_type value);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{kind: item_kind, pixel_in: value};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_items++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
   endtask

   task automatic program_filter(input logic big_kernel,
                                 input logic [CSR_DATA_BITS-1:0] c0, c1, c2, c3,
                                 input logic [SHIFT_BITS-1:0] shift,
                                 input logic [DIM_BITS-1:0] width, height);
      write_csr(CSR_KERNEL_SELECT, CSR_DATA_BITS'(big_kernel));
      write_csr(CSR_COEF_WORD0, c0);
      write_csr(CSR_COEF_WORD1, c1);
      write_csr(CSR_COEF_WORD2, c2);
      write_csr(CSR_COEF_WORD3, c3);
      write_csr(CSR_SCALE_SHIFT, CSR_DATA_BITS'(shift));
      write_csr(CSR_FRAME_WIDTH, CSR_DATA_BITS'(width));
      write_csr(CSR_FRAME_HEIGHT, CSR_DATA_BITS'(height));
      csr_write <= 1'b0;
      geo_width = (width < MIN_DIM) ? MIN_DIM : (width > MAX_WIDTH) ? MAX_WIDTH : width;
      geo_height = (height < MIN_DIM) ? MIN_DIM : height;
      geo_radius = big_kernel ? MAX_KERNEL / 2 : SMALL_KERNEL / 2;
   endtask

   // one frame of pixels, then the drain items; stray flushes mixed in
   task automatic run_frame(input bit directed);
      int unsigned total, drain;
      pixel_type   value;
      total = geo_width * geo_height;
      drain = geo_radius * geo_width + geo_radius;
      for (int unsigned n = 0; n < total; n++) begin
         if (directed ? (n == 20) : ($urandom_range(99) < 4))
            send_item(KIND_FLUSH, random_pixel());
         if (directed)
            value = (n == 0) ? pixel_type'(0) : (n == geo_width - 1) ? pixel_type'(-1) :
                    (n < total / 2) ? PIXEL_HIGH : PIXEL_LOW;
         else
            value = random_pixel();
         send_item(KIND_PIXEL, value);
      end
      for (int unsigned n = 0; n < drain; n++) begin
         if (directed ? (n == 0) : ($urandom_range(99) < 25))
            send_item(KIND_PIXEL, random_pixel());
         else
            send_item(KIND_FLUSH, random_pixel());
      end
      repeat ($urandom_range(2)) send_item(KIND_FLUSH, random_pixel());
      wait_idle();
   endtask

   initial begin : receiver
      int run;
      bit hold;
      @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold = 1'b1;
            run = HOLD_CYCLES;
         end else if ($urandom_range(99) < 30) begin
            hold = 1'b1;
            run = ($urandom_range(99) < 85) ? $urandom_range(3, 1) : $urandom_range(80, 20);
         end else begin
            hold = 1'b0;
            run = ($urandom_range(99) < 80) ? $urandom_range(8, 1) : $urandom_range(150, 40);
         end
         rsp_stall <= hold;
         repeat (run) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || csr_write || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic [DIM_BITS-1:0] width, height;
      int                  roll;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 8x8, 3x3, all-zero taps
      geo_width = MIN_DIM;
      geo_height = MIN_DIM;
      geo_radius = SMALL_KERNEL / 2;
      run_frame(1'b0);

      // saturation both ways, extreme taps
      program_filter(1'b0, 64'h7f7f_7f7f_7f7f_7f7f, 64'h0000_0000_0000_0080, '0, '0, '0,
                     DIM_BITS'(8), DIM_BITS'(8));
      run_frame(1'b1);

      // output held off while input keeps coming
      program_filter(1'b1, random_coefs(), random_coefs(), random_coefs(), random_coefs(),
                     SHIFT_BITS'($urandom_range(15)), DIM_BITS'(48), DIM_BITS'(16));
      sender_dense = 1'b1;
      long_hold_req = 1'b1;
      run_frame(1'b0);
      sender_dense = 1'b0;

      // width clamped up from zero
      program_filter(1'b0, '1, '1, random_coefs(), random_coefs(), '0, '0,
                     DIM_BITS'(24));
      run_frame(1'b0);

      while (sent_items < ITEM_TARGET) begin
         roll = $urandom_range(99);
         width = (roll < 85) ? DIM_BITS'($urandom_range(24, 8)) :
                 (roll < 95) ? DIM_BITS'($urandom_range(7, 0)) :
                 DIM_BITS'($urandom_range(64, 25));
         height = ($urandom_range(99) < 90) ? DIM_BITS'($urandom_range(14, 8)) :
                  DIM_BITS'($urandom_range(7, 0));
         program_filter(1'($urandom_range(1)), random_coefs(), random_coefs(),
                        random_coefs(), random_coefs(), SHIFT_BITS'($urandom_range(15)),
                        width, height);
         sender_dense = ($urandom_range(3) == 0);
         run_frame(1'b0);
      end

      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
